[hw/rtl/fpbs_pkg.sv]
// ----------------------------------------------------------------------------
// fpbs_pkg
// Shared types and constants for the double-precision integer power block.
// ----------------------------------------------------------------------------
package fpbs_pkg;

    localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] QNAN_BITS = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Request into the shared arithmetic unit.
    typedef struct packed {
        logic start;
        logic op;
    } fpu_req_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift;
        logic fpu_start;
        logic fpu_op;
        logic mul_base;
        logic wr_recip;
        logic wr_acc;
        logic res_one;
        logic res_acc;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pow_zero;
        logic pow_neg;
        logic mag_top;
        logic cnt_zero;
        logic fpu_done;
    } dp_status_t;

endpackage

[hw/rtl/fpbs_fpu.sv]
// ----------------------------------------------------------------------------
// fpbs_fpu
// Multi-cycle binary64 multiply and reciprocal with round to nearest even.
// ----------------------------------------------------------------------------
module fpbs_fpu
(
    input  logic              clk,
    input  logic              rst_n,
    input  fpbs_pkg::fpu_req_t req,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    output logic              done,
    output logic [63:0]       result
);
    import fpbs_pkg::*;

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_MUL   = 3'd1;
    localparam logic [2:0] F_DPRE  = 3'd2;
    localparam logic [2:0] F_DIV   = 3'd3;
    localparam logic [2:0] F_NORM  = 3'd4;
    localparam logic [2:0] F_ROUND = 3'd5;
    localparam logic [2:0] F_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [52:0]         ma_reg, ma_next, mb_reg, mb_next;
    logic [105:0]        p_reg, p_next;
    logic signed [13:0]  x_reg, x_next;
    logic [53:0]         r_reg, r_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic                s_reg, s_next;
    logic [63:0]         res_reg, res_next;

    // Operand decode.
    logic [10:0] ea_f, eb_f;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [52:0] ma_u, mb_u;
    logic [10:0] ea_u, eb_u;

    assign ea_f   = a[62:52];
    assign eb_f   = b[62:52];
    assign a_nan  = (ea_f == 11'h7FF) && (a[51:0] != 52'd0);
    assign b_nan  = (eb_f == 11'h7FF) && (b[51:0] != 52'd0);
    assign a_inf  = (ea_f == 11'h7FF) && (a[51:0] == 52'd0);
    assign b_inf  = (eb_f == 11'h7FF) && (b[51:0] == 52'd0);
    assign a_zero = (a[62:0] == 63'd0);
    assign b_zero = (b[62:0] == 63'd0);
    assign ma_u   = {(ea_f != 11'd0), a[51:0]};
    assign mb_u   = {(eb_f != 11'd0), b[51:0]};
    assign ea_u   = (ea_f == 11'd0) ? 11'd1 : ea_f;
    assign eb_u   = (eb_f == 11'd0) ? 11'd1 : eb_f;

    // Partial product of the 53x53 multiply, one per cycle.
    logic [26:0]  pp_x, pp_y;
    logic [53:0]  pp;
    logic [105:0] pp_sh;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                pp_x = ma_reg[26:0];
                pp_y = mb_reg[26:0];
            end
            2'd1:
            begin
                pp_x = ma_reg[26:0];
                pp_y = {1'b0, mb_reg[52:27]};
            end
            2'd2:
            begin
                pp_x = {1'b0, ma_reg[52:27]};
                pp_y = mb_reg[26:0];
            end
            default:
            begin
                pp_x = {1'b0, ma_reg[52:27]};
                pp_y = {1'b0, mb_reg[52:27]};
            end
        endcase
    end

    assign pp = pp_x * pp_y;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {52'd0, pp};
            2'd3:    pp_sh = {pp[51:0], 54'd0};
            default: pp_sh = {25'd0, pp, 27'd0};
        endcase
    end

    // Restoring division step.
    logic        div_ge;
    logic [53:0] div_rem;

    assign div_ge  = (r_reg >= {1'b0, mb_reg});
    assign div_rem = div_ge ? (r_reg - {1'b0, mb_reg}) : r_reg;

    // Rounding.
    logic [52:0] rnd_s;
    logic        rnd_g, rnd_st, rnd_inc, rnd_normal, rnd_ovf;
    logic [53:0] rnd_sum;
    logic [11:0] rnd_field;

    assign rnd_s      = p_reg[105:53];
    assign rnd_g      = p_reg[52];
    assign rnd_st     = (p_reg[51:0] != 52'd0);
    assign rnd_inc    = rnd_g & (rnd_st | rnd_s[0]);
    assign rnd_sum    = {1'b0, rnd_s} + {53'd0, rnd_inc};
    assign rnd_normal = p_reg[105];
    assign rnd_field  = rnd_normal ? (x_reg[11:0] + {11'd0, rnd_sum[53]})
                                   : {11'd0, rnd_sum[52]};
    assign rnd_ovf    = rnd_normal && ((x_reg > 14'sd2046) || (rnd_field >= 12'd2047));

    always_comb
    begin
        state_next = state_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        p_next     = p_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        res_next   = res_reg;

        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    ma_next  = ma_u;
                    mb_next  = mb_u;
                    p_next   = 106'd0;
                    cnt_next = 7'd0;
                    if (req.op == OP_MUL)
                    begin
                        s_next = a[63] ^ b[63];
                        x_next = $signed({3'b000, ea_u}) + $signed({3'b000, eb_u})
                                 - 14'sd1022;
                        state_next = F_DONE;
                        if (a_nan)
                            res_next = a | QUIET_BIT;
                        else if (b_nan)
                            res_next = b | QUIET_BIT;
                        else if ((a_inf && b_zero) || (a_zero && b_inf))
                            res_next = QNAN_BITS;
                        else if (a_inf || b_inf)
                            res_next = {a[63] ^ b[63], 11'h7FF, 52'd0};
                        else if (a_zero || b_zero)
                            res_next = {a[63] ^ b[63], 63'd0};
                        else
                            state_next = F_MUL;
                    end
                    else
                    begin
                        s_next = b[63];
                        x_next = 14'sd2045 - $signed({3'b000, eb_u});
                        state_next = F_DONE;
                        if (b_nan)
                            res_next = b | QUIET_BIT;
                        else if (b_inf)
                            res_next = {b[63], 63'd0};
                        else if (b_zero)
                            res_next = {b[63], 11'h7FF, 52'd0};
                        else
                            state_next = F_DPRE;
                    end
                end
            end
            F_MUL:
            begin
                p_next   = p_reg + pp_sh;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[1:0] == 2'd3)
                    state_next = F_NORM;
            end
            F_DPRE:
            begin
                // Bring a subnormal divisor up to a leading one at bit 52.
                if (mb_reg[52])
                begin
                    r_next     = {1'b1, 53'd0};
                    cnt_next   = 7'd0;
                    state_next = F_DIV;
                end
                else
                begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    x_next  = x_reg + 14'sd1;
                end
            end
            F_DIV:
            begin
                r_next   = {div_rem[52:0], 1'b0};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd104)
                begin
                    p_next     = {p_reg[103:0], div_ge, (div_rem != 54'd0)};
                    state_next = F_NORM;
                end
                else
                begin
                    p_next = {p_reg[104:0], div_ge};
                end
            end
            F_NORM:
            begin
                if (x_reg < 14'sd1)
                begin
                    if (x_reg < -14'sd120)
                    begin
                        p_next = {105'd0, (p_reg != 106'd0)};
                        x_next = 14'sd1;
                    end
                    else
                    begin
                        p_next = {1'b0, p_reg[105:2], p_reg[1] | p_reg[0]};
                        x_next = x_reg + 14'sd1;
                    end
                end
                else if (!p_reg[105] && (x_reg > 14'sd1))
                begin
                    p_next = {p_reg[104:0], 1'b0};
                    x_next = x_reg - 14'sd1;
                end
                else
                begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND:
            begin
                if (rnd_ovf)
                    res_next = {s_reg, 11'h7FF, 52'd0};
                else
                    res_next = {s_reg, rnd_field[10:0], rnd_sum[51:0]};
                state_next = F_DONE;
            end
            F_DONE:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        p_reg   <= p_next;
        x_reg   <= x_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
        s_reg   <= s_next;
        res_reg <= res_next;
    end

    assign done   = (state_reg == F_DONE);
    assign result = res_reg;

endmodule

[hw/rtl/fpbs_dpath.sv]
// ----------------------------------------------------------------------------
// fpbs_dpath
// Operand, exponent-bit and accumulator registers around the arithmetic unit.
// ----------------------------------------------------------------------------
module fpbs_dpath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpbs_pkg::ctrl_cmd_t  cmd,
    input  logic [63:0]          base_bits,
    input  logic signed [31:0]   power,
    output fpbs_pkg::dp_status_t status,
    output logic [63:0]          result_bits
);
    import fpbs_pkg::*;

    logic [63:0] base_reg, acc_reg, res_reg;
    logic [31:0] mag_reg;
    logic [4:0]  cnt_reg;
    logic        zero_reg, neg_reg;

    fpu_req_t    req;
    logic [63:0] fpu_a, fpu_b, fpu_res;
    logic        fpu_done;

    assign req.start = cmd.fpu_start;
    assign req.op    = cmd.fpu_op;
    assign fpu_a     = acc_reg;
    assign fpu_b     = (cmd.fpu_op == OP_DIV || cmd.mul_base) ? base_reg : acc_reg;

    fpbs_fpu u_fpu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .a      (fpu_a),
        .b      (fpu_b),
        .done   (fpu_done),
        .result (fpu_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base_bits;
            acc_reg  <= base_bits;
            zero_reg <= (power == 32'sd0);
            neg_reg  <= power[31];
            mag_reg  <= power[31] ? (~power + 32'd1) : power;
            cnt_reg  <= 5'd31;
        end
        else
        begin
            if (cmd.shift)
            begin
                mag_reg <= {mag_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
            end
            if (cmd.wr_recip)
            begin
                base_reg <= fpu_res;
                acc_reg  <= fpu_res;
            end
            else if (cmd.wr_acc)
            begin
                acc_reg <= fpu_res;
            end
        end
        if (cmd.res_one)
            res_reg <= ONE_BITS;
        else if (cmd.res_acc)
            res_reg <= acc_reg;
    end

    assign status.pow_zero = zero_reg;
    assign status.pow_neg  = neg_reg;
    assign status.mag_top  = mag_reg[31];
    assign status.cnt_zero = (cnt_reg == 5'd0);
    assign status.fpu_done = fpu_done;
    assign result_bits     = res_reg;

endmodule

[hw/rtl/fpbs_ctrl.sv]
// ----------------------------------------------------------------------------
// fpbs_ctrl
// Sequencer for reciprocal, leading-bit search and square-and-multiply.
// ----------------------------------------------------------------------------
module fpbs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fpbs_pkg::dp_status_t status,
    output fpbs_pkg::ctrl_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import fpbs_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_RECIP  = 4'd2;
    localparam logic [3:0] S_FIND   = 4'd3;
    localparam logic [3:0] S_NEXT   = 4'd4;
    localparam logic [3:0] S_SQ     = 4'd5;
    localparam logic [3:0] S_MSTART = 4'd6;
    localparam logic [3:0] S_MB     = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.pow_zero)
                begin
                    cmd.res_one = 1'b1;
                    state_next  = S_OUT;
                end
                else if (status.pow_neg)
                begin
                    cmd.fpu_start = 1'b1;
                    cmd.fpu_op    = OP_DIV;
                    state_next    = S_RECIP;
                end
                else
                begin
                    state_next = S_FIND;
                end
            end
            S_RECIP:
            begin
                cmd.fpu_op = OP_DIV;
                if (status.fpu_done)
                begin
                    cmd.wr_recip = 1'b1;
                    state_next   = S_FIND;
                end
            end
            S_FIND:
            begin
                if (status.mag_top)
                    state_next = S_NEXT;
                else
                    cmd.shift = 1'b1;
            end
            S_NEXT:
            begin
                if (status.cnt_zero)
                begin
                    cmd.res_acc = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    // The shift brings the next lower exponent bit to the top.
                    cmd.shift     = 1'b1;
                    cmd.fpu_start = 1'b1;
                    cmd.fpu_op    = OP_MUL;
                    state_next    = S_SQ;
                end
            end
            S_SQ:
            begin
                if (status.fpu_done)
                begin
                    cmd.wr_acc = 1'b1;
                    state_next = status.mag_top ? S_MSTART : S_NEXT;
                end
            end
            S_MSTART:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = OP_MUL;
                cmd.mul_base  = 1'b1;
                state_next    = S_MB;
            end
            S_MB:
            begin
                if (status.fpu_done)
                begin
                    cmd.wr_acc = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule

[hw/rtl/float_power_by_squaring.sv]
// Sequence: a zero exponent goes from the check state straight to done; otherwise
// the controller searches for the leading exponent bit, then runs each square or multiply
// (start, 4 partial products, normalize, round, done), with a reciprocal first for a
// negative exponent. Subnormal operands add normalization shifts.
// Throughput: one transfer at a time; start is taken only while busy is low.
// The result is shown for one cycle with done high; the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) returns both sequencers to idle.
// ----------------------------------------------------------------------------
// float_power_by_squaring
// Binary64 base raised to a signed 32-bit integer power by repeated squaring.
// ----------------------------------------------------------------------------
module float_power_by_squaring
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        base_bits,
    input  logic signed [31:0] power,
    output logic               busy,
    output logic               done,
    output logic [63:0]        result_bits
);
    import fpbs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    fpbs_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    fpbs_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .base_bits   (base_bits),
        .power       (power),
        .status      (status),
        .result_bits (result_bits)
    );

endmodule
